// ===== hw/rtl/priority_ready_queue_scheduler_top_defines.svh =====
// Assertion macros shared by the ready-queue scheduler RTL.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on i_clk outside reset.
`define PRQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prq assertion failed");
// Next-cycle implication, checked on i_clk outside reset.
`define PRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prq assertion failed");
`else
`define PRQ_ASSERT_NOW(label, ante, cons)
`define PRQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/prq_pkg.sv =====
// Types and constants of the ready-queue scheduler.
`default_nettype none
package prq_pkg;

    localparam int TID_W = 3;
    localparam int PRI_W = 4;

    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_TAKE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOCHANGE = 2'd1,
        ST_REFUSED  = 2'd2
    } t_status;

    typedef struct packed {
        t_op               operation;
        logic [TID_W-1:0]  thread_id;
        logic [PRI_W-1:0]  priority_req;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [TID_W-1:0]  next_thread;
        logic              next_valid;
    } t_res;

endpackage
`default_nettype wire

// ===== hw/rtl/prq_queue_state.sv =====
// Per-level FIFO heads and tails, thread links and flags, with their update logic.
`default_nettype none
`include "priority_ready_queue_scheduler_top_defines.svh"
module prq_queue_state
    import prq_pkg::*;
#(
    parameter int THREADS = 8,
    parameter int LEVELS  = 16,
    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1,
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire t_req           i_req,
    output t_status             o_status,
    output logic [LEVELS-1:0]   o_nonempty,
    output logic [TW-1:0]       o_head [LEVELS]
);

    logic [TW-1:0]      r_head [LEVELS];
    logic [TW-1:0]      r_tail [LEVELS];
    logic [LEVELS-1:0]  r_nonempty;
    logic [TW-1:0]      r_link [THREADS];
    logic [THREADS-1:0] r_has_link;
    logic [THREADS-1:0] r_ready;
    logic [LW-1:0]      r_level [THREADS];

    logic [TW-1:0]      n_head [LEVELS];
    logic [TW-1:0]      n_tail [LEVELS];
    logic [LEVELS-1:0]  n_nonempty;
    logic [TW-1:0]      n_link [THREADS];
    logic [THREADS-1:0] n_has_link;
    logic [THREADS-1:0] n_ready;
    logic [LW-1:0]      n_level [THREADS];

    logic               tid_ok;
    logic [TW-1:0]      t;
    logic [LW-1:0]      lvl_put;
    logic [LW-1:0]      lvl_take;
    logic [TW-1:0]      tl;
    t_status            status;

    assign tid_ok   = int'(i_req.thread_id) < THREADS;
    assign t        = TW'(i_req.thread_id);
    // Levels beyond the configured range saturate to the lowest priority.
    assign lvl_put  = (int'(i_req.priority_req) >= LEVELS) ? LW'(LEVELS - 1)
                                                           : LW'(i_req.priority_req);
    assign lvl_take = r_level[t];
    assign tl       = r_tail[lvl_put];

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_nonempty = r_nonempty;
        n_link     = r_link;
        n_has_link = r_has_link;
        n_ready    = r_ready;
        n_level    = r_level;
        status     = ST_NOCHANGE;
        if (i_en && tid_ok) begin
            if (i_req.operation == OP_PUT) begin
                if (!r_ready[t]) begin
                    status = ST_DONE;
                    if (r_nonempty[lvl_put]) begin
                        n_link[tl]     = t;
                        n_has_link[tl] = 1'b1;
                    end else begin
                        n_head[lvl_put]     = t;
                        n_nonempty[lvl_put] = 1'b1;
                    end
                    n_tail[lvl_put] = t;
                    n_has_link[t]   = 1'b0;
                    n_ready[t]      = 1'b1;
                    n_level[t]      = lvl_put;
                end
            end else if (r_ready[t]) begin
                if (!r_nonempty[lvl_take] || (r_head[lvl_take] != t)) begin
                    status = ST_REFUSED;
                end else begin
                    status = ST_DONE;
                    if (r_has_link[t]) begin
                        n_head[lvl_take] = r_link[t];
                    end else begin
                        n_nonempty[lvl_take] = 1'b0;
                    end
                    n_has_link[t] = 1'b0;
                    n_ready[t]    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '{default: '0};
            r_tail     <= '{default: '0};
            r_nonempty <= '0;
            r_has_link <= '0;
            r_ready    <= '0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_nonempty <= n_nonempty;
            r_has_link <= n_has_link;
            r_ready    <= n_ready;
        end
    end

    // Links and recorded levels are only read behind their flags.
    always_ff @(posedge i_clk) begin
        r_link  <= n_link;
        r_level <= n_level;
    end

    assign o_status   = status;
    assign o_nonempty = n_nonempty;
    assign o_head     = n_head;

    // A level holds a thread exactly when some thread is ready.
    `PRQ_ASSERT_NOW(a_ready_has_level, (|r_ready), (|r_nonempty))
    `PRQ_ASSERT_NOW(a_level_has_ready, (|r_nonempty), (|r_ready))

endmodule
`default_nettype wire

// ===== hw/rtl/prq_head_select.sv =====
// Picks the head thread of the highest-priority non-empty level.
`default_nettype none
module prq_head_select
    import prq_pkg::*;
#(
    parameter int THREADS = 8,
    parameter int LEVELS  = 16,
    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1
) (
    input  wire logic [LEVELS-1:0] i_nonempty,
    input  wire logic [TW-1:0]     i_head [LEVELS],
    output logic [TID_W-1:0]       o_next_thread,
    output logic                   o_next_valid
);

    logic [LEVELS-1:0] first;
    logic [TW-1:0]     sel;

    // Isolate the lowest set bit; level 0 is the highest priority.
    assign first = i_nonempty & ~(i_nonempty - LEVELS'(1));

    always_comb begin
        sel = '0;
        for (int i = 0; i < LEVELS; i++) begin
            sel = sel | (i_head[i] & {TW{first[i]}});
        end
    end

    assign o_next_thread = TID_W'(sel);
    assign o_next_valid  = |i_nonempty;

endmodule
`default_nettype wire

// ===== hw/rtl/priority_ready_queue_scheduler_top.sv =====
// Top level of the multilevel priority FIFO ready-queue scheduler.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   request  | i_in_valid / o_in_ready    | i_operation, i_thread_id, i_priority_req
//   result   | o_out_valid / i_out_ready  | o_status, o_next_thread, o_next_valid
//
// Each request item passes the input register, then the result register, before
// its result item is presented. One item enters per cycle while the result side
// keeps taking; the path from the input register through the queue update and the
// head priority encoder to the result register is combinational.
// Reset (synchronous, active low) empties every level and clears all ready flags.
// A stalled result holds its register; the input register then fills and
// o_in_ready drops until the result is taken.
`default_nettype none
`include "priority_ready_queue_scheduler_top_defines.svh"
module priority_ready_queue_scheduler_top
    import prq_pkg::*;
#(
    parameter int THREADS = 8,
    parameter int LEVELS  = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_operation,
    input  wire logic [TID_W-1:0] i_thread_id,
    input  wire logic [PRI_W-1:0] i_priority_req,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [1:0]            o_status,
    output logic [TID_W-1:0]      o_next_thread,
    output logic                  o_next_valid
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;

    // Input register: holds one accepted request item.
    logic  r_in_valid;
    t_req  r_req;
    // Result register: holds one finished result item.
    logic  r_out_valid;
    t_res  r_res;

    logic              advance;
    t_status           status;
    logic [LEVELS-1:0] nonempty;
    logic [TW-1:0]     head [LEVELS];
    logic [TID_W-1:0]  next_thread;
    logic              next_valid;
    t_res              n_res;

    // The held request moves on when the result register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req <= '{operation:    t_op'(i_operation),
                       thread_id:    i_thread_id,
                       priority_req: i_priority_req};
        end
    end

    // The queue state only changes when a request actually advances.
    prq_queue_state #(
        .THREADS (THREADS),
        .LEVELS  (LEVELS)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_req      (r_req),
        .o_status   (status),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    // The reported head reflects the queues after this request is applied.
    prq_head_select #(
        .THREADS (THREADS),
        .LEVELS  (LEVELS)
    ) u_select (
        .i_nonempty    (nonempty),
        .i_head        (head),
        .o_next_thread (next_thread),
        .o_next_valid  (next_valid)
    );

    assign n_res = '{status:      status,
                     next_thread: next_thread,
                     next_valid:  next_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_res.status;
    assign o_next_thread = r_res.next_thread;
    assign o_next_valid  = r_res.next_valid;

    // Ready only drops when both registers are full and the result is stalled.
    `PRQ_ASSERT_NOW(a_ready_low_means_stall, (!o_in_ready), (r_in_valid && r_out_valid && !i_out_ready))
    // A request that advances always leaves a result behind.
    `PRQ_ASSERT_NEXT(a_advance_gives_result, advance, r_out_valid)
    // With no ready thread the reported head is zero.
    `PRQ_ASSERT_NOW(a_idle_head_zero, (r_out_valid && !r_res.next_valid), (r_res.next_thread == '0))

endmodule
`default_nettype wire

// ===== verif/priority_ready_queue_scheduler_top_tb.sv =====
// Self-checking testbench for the multilevel priority FIFO ready-queue scheduler.
`timescale 1ns / 100ps
module priority_ready_queue_scheduler_top_tb;
    import prq_pkg::*;

    localparam int NUM_THREADS = 8;
    localparam int NUM_LEVELS  = 16;
    // Cycles without any accepted item on either channel before the run is abandoned.
    localparam int IDLE_LIMIT  = 1000;
    // Extra cycles the drain at the end waits once every owed answer is taken.
    localparam int DRAIN_CYCLES = 8;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_operation = OP_PUT;
    logic [TID_W-1:0] i_thread_id = '0;
    logic [PRI_W-1:0] i_priority_req = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [1:0]       o_status;
    logic [TID_W-1:0] o_next_thread;
    logic             o_next_valid;

    priority_ready_queue_scheduler_top #(
        .THREADS(NUM_THREADS),
        .LEVELS (NUM_LEVELS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_thread_id   (i_thread_id),
        .i_priority_req(i_priority_req),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_next_thread (o_next_thread),
        .o_next_valid  (o_next_valid)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the ready queue. Each level is a singly linked FIFO of
    // threads, chained through a per-thread link register.
    logic [TID_W-1:0] lvl_head [NUM_LEVELS];
    logic [TID_W-1:0] lvl_tail [NUM_LEVELS];
    logic             lvl_busy [NUM_LEVELS];
    logic [TID_W-1:0] th_next  [NUM_THREADS];
    logic             th_linked[NUM_THREADS];
    logic             th_ready [NUM_THREADS];
    logic [PRI_W-1:0] th_level [NUM_THREADS];

    // Scheduler answers still owed by the block, oldest first.
    t_res owed_answers[$];
    int   mismatch_count = 0;

    // Sender burst control.
    bit   gaps_enabled = 1'b0;
    int   burst_left = 0;

    // Receiver stall pattern state.
    logic [11:0] stall_cycle = '0;
    int          stall_run = 0;

    int   idle_cycles = 0;

    // Applies one request to the shadow queue and returns the answer the block
    // must give for it. The priority field spans exactly the sixteen levels, so
    // the saturation of out-of-range levels can never come into play here.
    function automatic t_res schedule_request(input t_op op, input logic [TID_W-1:0] tid,
                                              input logic [PRI_W-1:0] pri);
        t_res             res;
        logic [PRI_W-1:0] lvl;
        res.status      = ST_NOCHANGE;
        res.next_thread = '0;
        res.next_valid  = 1'b0;
        if (op == OP_PUT) begin
            if (!th_ready[tid]) begin
                lvl = pri;
                if (lvl_busy[lvl]) begin
                    th_next[lvl_tail[lvl]]   = tid;
                    th_linked[lvl_tail[lvl]] = 1'b1;
                end else begin
                    lvl_head[lvl] = tid;
                    lvl_busy[lvl] = 1'b1;
                end
                lvl_tail[lvl]  = tid;
                th_linked[tid] = 1'b0;
                th_ready[tid]  = 1'b1;
                th_level[tid]  = lvl;
                res.status     = ST_DONE;
            end
        end else if (th_ready[tid]) begin
            lvl = th_level[tid];
            if (!lvl_busy[lvl] || lvl_head[lvl] != tid) begin
                res.status = ST_REFUSED;
            end else begin
                if (th_linked[tid])
                    lvl_head[lvl] = th_next[tid];
                else
                    lvl_busy[lvl] = 1'b0;
                th_linked[tid] = 1'b0;
                th_ready[tid]  = 1'b0;
                res.status     = ST_DONE;
            end
        end
        // Scan from the highest-numbered level down; level 0 wins, so the last hit stands.
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (lvl_busy[i]) begin
                res.next_thread = lvl_head[i];
                res.next_valid  = 1'b1;
            end
        end
        return res;
    endfunction

    // Presents one request item and holds it until the block takes it. Called
    // only at a rising edge; on return the item was accepted at that edge.
    task automatic send_request(input t_op op, input logic [TID_W-1:0] tid,
                                input logic [PRI_W-1:0] pri);
        int gap;
        if (gaps_enabled) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 32);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_thread_id    <= tid;
        i_priority_req <= pri;
        do @(posedge i_clk); while (!o_in_ready);
        owed_answers.push_back(schedule_request(op, tid, pri));
    endtask

    // Each request field at both ends of its range, every operation, and each
    // special case: put of a ready thread, take of an idle thread, take of a
    // ready thread behind the head, and an empty queue.
    task automatic test_field_extremes();
        send_request(OP_TAKE, 3'd3, 4'd0);   // nothing ready at all
        send_request(OP_PUT,  3'd0, 4'd15);
        send_request(OP_PUT,  3'd7, 4'd15);
        send_request(OP_PUT,  3'd0, 4'd0);   // already ready, level kept
        send_request(OP_TAKE, 3'd7, 4'd15);  // ready but behind thread 0
        send_request(OP_PUT,  3'd5, 4'd0);
        send_request(OP_TAKE, 3'd0, 4'd9);
        send_request(OP_TAKE, 3'd5, 4'd0);
        send_request(OP_TAKE, 3'd7, 4'd0);   // queue empty again
        send_request(OP_TAKE, 3'd7, 4'd15);  // idle thread
    endtask

    // The reported head follows the lowest-numbered level that holds a thread.
    task automatic test_level_order();
        send_request(OP_PUT,  3'd1, 4'd9);
        send_request(OP_PUT,  3'd2, 4'd3);
        send_request(OP_PUT,  3'd4, 4'd3);
        send_request(OP_PUT,  3'd6, 4'd14);
        send_request(OP_TAKE, 3'd4, 4'd0);
        send_request(OP_TAKE, 3'd2, 4'd0);
        send_request(OP_TAKE, 3'd4, 4'd0);
        send_request(OP_TAKE, 3'd1, 4'd0);
        send_request(OP_TAKE, 3'd6, 4'd0);
    endtask

    // Mostly well-formed traffic: takes from the head of a populated level and
    // puts of idle threads, half of them crowded onto levels 0 to 3 so the FIFOs grow deep.
    // The rest is unconstrained requests that hit the refusal and no-change paths.
    task automatic test_random_traffic(input int count, input bit with_gaps);
        int               n;
        int               start;
        int               lvl;
        int               idle_count;
        bit               any_busy;
        t_op              op;
        logic [TID_W-1:0] tid;
        logic [PRI_W-1:0] pri;
        gaps_enabled = with_gaps;
        burst_left   = 0;
        for (n = 0; n < count; n++) begin
            op  = t_op'($urandom_range(0, 1));
            tid = TID_W'($urandom_range(0, NUM_THREADS - 1));
            pri = PRI_W'($urandom_range(0, NUM_LEVELS - 1));
            if ($urandom_range(0, 99) < 75) begin
                any_busy   = 1'b0;
                idle_count = 0;
                for (int i = 0; i < NUM_LEVELS; i++)
                    any_busy |= lvl_busy[i];
                for (int i = 0; i < NUM_THREADS; i++)
                    idle_count += !th_ready[i];
                if (any_busy && (idle_count == 0 || $urandom_range(0, 9) < 4)) begin
                    start = $urandom_range(0, NUM_LEVELS - 1);
                    lvl   = start;
                    while (!lvl_busy[lvl])
                        lvl = (lvl + 1) % NUM_LEVELS;
                    op  = OP_TAKE;
                    tid = lvl_head[lvl];
                end else begin
                    while (th_ready[tid])
                        tid = TID_W'((tid + 1) % NUM_THREADS);
                    op = OP_PUT;
                    if ($urandom_range(0, 1))
                        pri = PRI_W'($urandom_range(0, 3));
                end
            end
            send_request(op, tid, pri);
        end
        gaps_enabled = 1'b0;
    endtask

    // Receiver: cycles through four stall styles in turn:
    // always ready, coin flip, one cycle in four, and long alternating runs.
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 1'b1;
        case (stall_cycle[9:8])
            2'd0: begin
                i_out_ready <= 1'b1;
            end
            2'd1: begin
                i_out_ready <= ($urandom_range(0, 1) == 1);
            end
            2'd2: begin
                i_out_ready <= (stall_cycle[1:0] == 2'b00);
            end
            default: begin
                if (stall_run == 0) begin
                    stall_run   <= $urandom_range(1, 12);
                    i_out_ready <= ~i_out_ready;
                end else begin
                    stall_run <= stall_run - 1;
                end
            end
        endcase
    end

    // Result checker. Values read here are those held just before the edge.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_answers.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result item: status %0d next %0d valid %0d",
                         $time, o_status, o_next_thread, o_next_valid);
            end else begin
                want = owed_answers.pop_front();
                if (o_status !== want.status) begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
                if (o_next_thread !== want.next_thread) begin
                    mismatch_count++;
                    $display("%0t: next_thread expected %0d actual %0d",
                             $time, want.next_thread, o_next_thread);
                end
                if (o_next_valid !== want.next_valid) begin
                    mismatch_count++;
                    $display("%0t: next_valid expected %0d actual %0d",
                             $time, want.next_valid, o_next_valid);
                end
            end
        end
    end

    // Watchdog: a long spell with no item moving on either channel means a hang.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL priority_ready_queue_scheduler_top");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            lvl_head[i] = '0;
            lvl_tail[i] = '0;
            lvl_busy[i] = 1'b0;
        end
        for (int i = 0; i < NUM_THREADS; i++) begin
            th_next[i]   = '0;
            th_linked[i] = 1'b0;
            th_ready[i]  = 1'b0;
            th_level[i]  = '0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_level_order();
        test_random_traffic(230, 1'b0);
        test_random_traffic(900, 1'b1);

        i_in_valid <= 1'b0;
        while (owed_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("PASS priority_ready_queue_scheduler_top");
        else
            $display("FAIL priority_ready_queue_scheduler_top");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/prq_pkg.sv
hw/rtl/prq_queue_state.sv
hw/rtl/prq_head_select.sv
hw/rtl/priority_ready_queue_scheduler_top.sv
verif/priority_ready_queue_scheduler_top_tb.sv
